[rtl/assert_macros.svh]
// Assertion helpers included by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/cbm_pkg.sv]
package cbm_pkg;

   localparam int RAM_DEPTH    = 8192;
   localparam int RAM_ADDR_W   = $clog2(RAM_DEPTH);
   localparam int MAX_ROM_BANK = 31;

   localparam int ADDR_W       = 16;
   localparam int BYTE_W       = 8;
   localparam int LOW_BANK_W   = 7;
   localparam int HIGH_BANK_W  = 2;
   localparam int BANK_SUM_W   = 8;
   localparam int WIN_BITS     = 14;
   localparam int ROM_OFFSET_W = 19;

   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 32;

   localparam logic [ADDR_W-1:0] ENABLE_LAST = 16'h1FFF;
   localparam logic [ADDR_W-1:0] LOW_LAST    = 16'h3FFF;
   localparam logic [ADDR_W-1:0] HIGH_LAST   = 16'h5FFF;
   localparam logic [ADDR_W-1:0] CTL_LAST    = 16'h7FFF;
   localparam logic [ADDR_W-1:0] RAM_BASE    = 16'hA000;
   localparam logic [ADDR_W-1:0] RAM_LAST    = 16'hBFFF;

   localparam logic [3:0]        ENABLE_KEY  = 4'hA;
   localparam logic [BYTE_W-1:0] LOW_MASK    = 8'h1F;
   localparam logic [BYTE_W-1:0] QUIRK_A     = 8'h20;
   localparam logic [BYTE_W-1:0] QUIRK_B     = 8'h40;
   localparam logic [BYTE_W-1:0] QUIRK_C     = 8'h60;
   localparam logic [BYTE_W-1:0] HIGH_MAX    = 8'h03;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ROM      = 2'd0,
      KIND_RAM_BYTE = 2'd1,
      KIND_WRITE_OK = 2'd2,
      KIND_UNMAPPED = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      rsp_kind_type                    kind;
      logic [ROM_OFFSET_W-1:0]         rom_offset;
      logic                            ram_enabled;
      logic [HIGH_BANK_W-1:0]          ext_bank;
   } stage_type;

endpackage

[rtl/cbm_ram.sv]
module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cartridge_bank_mapper_unit.sv]
// Cartridge bank mapper. Takes one CPU bus access per cycle when not stalled and answers
// each with one item through the stage-one and result registers. Bank control
// writes update the bank registers at acceptance, so the very next access sees them.
// The 8 KiB external RAM is a single-port-write, registered-read memory; its read
// register lines up with stage one. Sustained rate is one item per cycle without stalls.
`include "assert_macros.svh"

module cartridge_bank_mapper_unit import cbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // address[15:0], write_data[23:16]
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // rom_offset[18:0], ram_byte[26:19],
                                             // ram_enabled[27], ram_bank_number[29:28]
   output logic [1:0]            rsp_tuser   // result_kind
);

   logic [LOW_BANK_W-1:0]  low_bank_ff, low_bank_in;
   logic [HIGH_BANK_W-1:0] high_bank_ff, high_bank_in;
   logic [HIGH_BANK_W-1:0] ext_bank_ff, ext_bank_in;
   logic                   ram_mode_ff, ram_mode_in;
   logic                   ram_enable_ff, ram_enable_in;

   logic                   s1_valid_ff, s1_valid_in;
   stage_type              s1_ff, s1_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   stage_type              rsp_ff;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;

   logic                   req_accept;
   logic                   s1_adv;
   logic                   is_write;
   logic                   is_ctl;
   logic                   is_ram;
   logic [ADDR_W-1:0]      addr;
   logic [BYTE_W-1:0]      wdata;
   logic [RAM_ADDR_W-1:0]  ram_idx;
   logic [BYTE_W-1:0]      ram_rd_data;
   logic [BANK_SUM_W-1:0]  bank_sum;
   logic [BANK_SUM_W-1:0]  bank_clamped;
   logic [BANK_SUM_W+WIN_BITS-1:0] rom_win;
   logic [ROM_OFFSET_W-1:0] rom_off;

   assign addr       = req_tdata[ADDR_W-1:0];
   assign wdata      = req_tdata[ADDR_W+BYTE_W-1:ADDR_W];
   assign is_write   = req_tuser == FUNC_WRITE;
   assign is_ctl     = addr <= CTL_LAST;
   assign is_ram     = (addr >= RAM_BASE) && (addr <= RAM_LAST);
   assign ram_idx    = RAM_ADDR_W'(addr - RAM_BASE);

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   // bank control writes
   always_comb begin
      low_bank_in   = low_bank_ff;
      high_bank_in  = high_bank_ff;
      ext_bank_in   = ext_bank_ff;
      ram_mode_in   = ram_mode_ff;
      ram_enable_in = ram_enable_ff;
      if (req_accept && is_write && is_ctl) begin
         priority if (addr <= ENABLE_LAST) begin
            ram_enable_in = wdata[3:0] == ENABLE_KEY;
         end else if (addr <= LOW_LAST) begin
            priority if (wdata == '0) begin
               low_bank_in = LOW_BANK_W'(1);
            end else if (wdata == QUIRK_A || wdata == QUIRK_B || wdata == QUIRK_C) begin
               low_bank_in = LOW_BANK_W'(wdata + BYTE_W'(1));
            end else begin
               low_bank_in = LOW_BANK_W'(wdata & LOW_MASK);
            end
         end else if (addr <= HIGH_LAST) begin
            priority if (ram_mode_ff) begin
               ext_bank_in = wdata[HIGH_BANK_W-1:0];
            end else if (wdata <= HIGH_MAX) begin
               high_bank_in = wdata[HIGH_BANK_W-1:0];
            end else begin
               high_bank_in = high_bank_ff;
            end
         end else begin
            ram_mode_in = wdata[0];
         end
      end
   end

   // ROM offset, switchable window clamped
   always_comb begin
      bank_sum     = BANK_SUM_W'({high_bank_ff, 5'b0}) + BANK_SUM_W'(low_bank_ff);
      bank_clamped = (bank_sum > BANK_SUM_W'(MAX_ROM_BANK)) ?
                     BANK_SUM_W'(MAX_ROM_BANK) : bank_sum;
      rom_win      = {bank_clamped, addr[WIN_BITS-1:0]};
      rom_off      = (addr <= LOW_LAST) ? ROM_OFFSET_W'(addr) : rom_win[ROM_OFFSET_W-1:0];
   end

   always_comb begin
      s1_in             = s1_ff;
      s1_in.rom_offset  = '0;
      s1_in.ram_enabled = ram_enable_in;
      s1_in.ext_bank    = ext_bank_in;
      priority if (is_ctl) begin
         s1_in.kind = is_write ? KIND_WRITE_OK : KIND_ROM;
         if (!is_write) begin
            s1_in.rom_offset = rom_off;
         end
      end else if (is_ram) begin
         s1_in.kind = is_write ? KIND_WRITE_OK : KIND_RAM_BYTE;
      end else begin
         s1_in.kind = KIND_UNMAPPED;
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_valid_ff && s1_adv) || (rsp_valid_ff && !rsp_tready);
   assign rsp_byte_in  = (s1_ff.kind == KIND_RAM_BYTE) ? ram_rd_data : '0;

   cbm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_accept && is_ram && is_write),
      .wr_addr (ram_idx),
      .wr_data (wdata),
      .rd_en   (req_accept && is_ram && !is_write),
      .rd_addr (ram_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bank_ff   <= LOW_BANK_W'(1);
         high_bank_ff  <= '0;
         ext_bank_ff   <= '0;
         ram_mode_ff   <= 1'b0;
         ram_enable_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_bank_ff   <= low_bank_in;
         high_bank_ff  <= high_bank_in;
         ext_bank_ff   <= ext_bank_in;
         ram_mode_ff   <= ram_mode_in;
         ram_enable_ff <= ram_enable_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_ff      <= s1_ff;
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.ext_bank, rsp_ff.ram_enabled, rsp_byte_ff,
                                    rsp_ff.rom_offset});

   `ASSERT_IMPLY(a_no_accept_on_stall, clock, reset, s1_valid_ff && !s1_adv, !req_accept, "item accepted while stage one is blocked")
   `ASSERT_NEXT(a_bank_hold_idle, clock, reset, !req_accept, $stable(high_bank_ff) && $stable(low_bank_ff), "bank register moved without an item")
   `ASSERT_NEXT(a_mode_guards_high, clock, reset, req_accept && ram_mode_ff, $stable(high_bank_ff), "high bank written in RAM mode")
   `ASSERT_IMPLY(a_byte_only_ram, clock, reset, rsp_valid_ff && rsp_ff.kind != KIND_RAM_BYTE, rsp_byte_ff == '0, "RAM byte set on a non-RAM result")
   `ASSERT_IMPLY(a_offset_only_rom, clock, reset, rsp_valid_ff && rsp_ff.kind != KIND_ROM, rsp_ff.rom_offset == '0, "ROM offset set on a non-ROM result")

endmodule

[tb/testbench.sv]
module testbench;
   import cbm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      rsp_kind_type            kind;
      logic [ROM_OFFSET_W-1:0] rom_offset;
      logic [BYTE_W-1:0]       ram_byte;
      logic                    ram_enabled;
      logic [HIGH_BANK_W-1:0]  ext_bank;
   } access_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // address[15:0], write_data[23:16]
   logic                  req_tuser = 1'b0;  // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // rom_offset[18:0], ram_byte[26:19],
                                      // ram_enabled[27], ram_bank_number[29:28]
   logic [1:0]            rsp_tuser;  // result_kind

   // mapper shadow state
   logic [LOW_BANK_W-1:0]  bank_low = LOW_BANK_W'(1);
   logic [HIGH_BANK_W-1:0] bank_high = '0;
   logic [HIGH_BANK_W-1:0] ext_bank_sel = '0;
   logic                   mode_ram = 1'b0;
   logic                   ram_on = 1'b0;
   logic [BYTE_W-1:0]      ram_image [RAM_DEPTH];
   int                     written_slots [$];

   access_result_type expected_results [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int kind_seen [4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   cartridge_bank_mapper_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // updates shadow state and returns the answer for one access
   function automatic access_result_type map_access(logic func, logic [ADDR_W-1:0] addr,
                                                    logic [BYTE_W-1:0] data);
      access_result_type r;
      int             bank;
      int             slot;
      r = '0;
      r.kind = KIND_UNMAPPED;
      if (addr <= CTL_LAST) begin
         if (func == FUNC_WRITE) begin
            r.kind = KIND_WRITE_OK;
            if (addr <= ENABLE_LAST) begin
               ram_on = (data[3:0] == ENABLE_KEY);
            end else if (addr <= LOW_LAST) begin
               if (data == '0)
                  bank_low = LOW_BANK_W'(1);
               else if (data == QUIRK_A || data == QUIRK_B || data == QUIRK_C)
                  bank_low = LOW_BANK_W'(data + 1);
               else
                  bank_low = LOW_BANK_W'(data & LOW_MASK);
            end else if (addr <= HIGH_LAST) begin
               if (mode_ram)
                  ext_bank_sel = data[HIGH_BANK_W-1:0];
               else if (data <= HIGH_MAX)
                  bank_high = data[HIGH_BANK_W-1:0];
            end else begin
               mode_ram = data[0];
            end
         end else begin
            r.kind = KIND_ROM;
            if (addr <= LOW_LAST) begin
               r.rom_offset = ROM_OFFSET_W'(addr);
            end else begin
               bank = (int'(bank_high) << 5) + int'(bank_low);
               if (bank > MAX_ROM_BANK)
                  bank = MAX_ROM_BANK;
               r.rom_offset = ROM_OFFSET_W'((bank << WIN_BITS) + int'(addr) - (1 << WIN_BITS));
            end
         end
      end else if (addr >= RAM_BASE && addr <= RAM_LAST) begin
         slot = int'(addr - RAM_BASE);
         if (func == FUNC_WRITE) begin
            r.kind = KIND_WRITE_OK;
            ram_image[slot] = data;
            written_slots.push_back(slot);
         end else begin
            r.kind = KIND_RAM_BYTE;
            r.ram_byte = ram_image[slot];
         end
      end
      r.ram_enabled = ram_on;
      r.ext_bank = ext_bank_sel;
      return r;
   endfunction

   task automatic send_access(logic func, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      access_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {data, addr};
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
      r = map_access(func, addr, data);
      expected_results.push_back(r);
      kind_seen[r.kind]++;
      sent_count++;
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      access_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item, expected none, got tdata 0x%0h kind %0d",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(rsp_tuser));
            compare_field("rom_offset", 32'(want.rom_offset), 32'(rsp_tdata[18:0]));
            compare_field("ram_byte", 32'(want.ram_byte), 32'(rsp_tdata[26:19]));
            compare_field("ram_enabled", 32'(want.ram_enabled), 32'(rsp_tdata[27]));
            compare_field("ram_bank_number", 32'(want.ext_bank), 32'(rsp_tdata[29:28]));
            checked_count++;
         end
      end
   end

   task automatic test_reset_state();
      send_access(FUNC_READ, 16'h0000, 8'h00);
      send_access(FUNC_READ, 16'h3FFF, 8'hFF);
      send_access(FUNC_READ, 16'h4000, 8'h00);
      send_access(FUNC_READ, 16'h7FFF, 8'h00);
   endtask

   task automatic test_bank_select();
      send_access(FUNC_WRITE, 16'h2000, 8'h00);
      send_access(FUNC_WRITE, 16'h3FFF, 8'h20);
      send_access(FUNC_READ, 16'h4123, 8'h00);
      send_access(FUNC_WRITE, 16'h2ABC, 8'h60);
      send_access(FUNC_WRITE, 16'h4000, 8'h03);
      send_access(FUNC_READ, 16'h7FFF, 8'h00);  // clamped
      send_access(FUNC_WRITE, 16'h5FFF, 8'h04);  // ignored
      send_access(FUNC_WRITE, 16'h2000, 8'h80);
      send_access(FUNC_WRITE, 16'h4000, 8'h00);
      send_access(FUNC_READ, 16'h4000, 8'h00);  // bank zero
   endtask

   task automatic test_ram_control();
      send_access(FUNC_WRITE, 16'h0000, 8'h0A);
      send_access(FUNC_WRITE, 16'h1FFF, 8'hA5);
      send_access(FUNC_WRITE, 16'h6000, 8'h01);
      send_access(FUNC_WRITE, 16'h4000, 8'hFE);
      send_access(FUNC_WRITE, 16'h7FFF, 8'h00);
   endtask

   task automatic test_external_ram();
      send_access(FUNC_WRITE, RAM_BASE, 8'h00);
      send_access(FUNC_WRITE, RAM_LAST, 8'hFF);
      send_access(FUNC_READ, RAM_BASE, 8'h00);
      send_access(FUNC_READ, RAM_LAST, 8'h00);
   endtask

   task automatic test_unmapped();
      send_access(FUNC_READ, 16'h8000, 8'h00);
      send_access(FUNC_WRITE, 16'h9FFF, 8'hFF);
      send_access(FUNC_READ, 16'hC000, 8'h00);
      send_access(FUNC_WRITE, 16'hFFFF, 8'h5A);
   endtask

   function automatic logic [BYTE_W-1:0] control_byte();
      case ($urandom_range(7))
         0: return '0;
         1: return 8'(QUIRK_A + ($urandom_range(2) << 5));
         2: return 8'($urandom_range(0, 3));
         3: return {4'($urandom_range(15)), ENABLE_KEY};
         4: return 8'h80;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_random_traffic(int count, int send_pct, int recv_pct);
      int pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send_access(FUNC_WRITE, 16'($urandom_range(0, CTL_LAST)), control_byte());
         end else if (pick < 53) begin
            send_access(FUNC_READ, 16'($urandom_range(0, CTL_LAST)), 8'($urandom_range(255)));
         end else if (pick < 70 || written_slots.size() == 0) begin
            send_access(FUNC_WRITE, 16'($urandom_range(RAM_BASE, RAM_LAST)),
                        8'($urandom_range(255)));
         end else if (pick < 88) begin
            send_access(FUNC_READ,
                        RAM_BASE + 16'(written_slots[$urandom_range(written_slots.size() - 1)]),
                        8'($urandom_range(255)));
         end else if (pick < 94) begin
            send_access(1'($urandom_range(1)), 16'($urandom_range(16'h8000, 16'h9FFF)),
                        8'($urandom_range(255)));
         end else begin
            send_access(1'($urandom_range(1)), 16'($urandom_range(16'hC000, 16'hFFFF)),
                        8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 14;
      recv_idle_pct = 64;
      test_reset_state();
      test_bank_select();
      test_ram_control();
      test_external_ram();
      test_unmapped();
      test_random_traffic(410, 14, 64);
      test_random_traffic(410, 64, 14);
      test_random_traffic(410, 0, 0);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         error_count++;
      end
      $display("Sent %0d accesses, checked %0d answers, %0d field errors",
               sent_count, checked_count, error_count);
      $display("ROM reads %0d, RAM reads %0d, writes %0d, unmapped %0d",
               kind_seen[KIND_ROM], kind_seen[KIND_RAM_BYTE], kind_seen[KIND_WRITE_OK],
               kind_seen[KIND_UNMAPPED]);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
